@@ design/mjpid_pkg.sv @@
// Shared types and constants for the multi-joint PID controller.
// No dependencies; imported by every design module.
`timescale 1ns / 1ps

package mjpid_pkg;

  localparam int CFG_REGS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int GAIN_W     = 16;
  localparam int JOINT_W    = 3;
  localparam int POS_W      = 32;
  localparam int ERR_W      = POS_W + 1;
  localparam int INTEG_W    = 40;
  localparam int CLAMP_W    = GAIN_W + 1 + 8;
  localparam int PE_PROD_W  = GAIN_W + ERR_W;
  localparam int INT_PROD_W = GAIN_W + INTEG_W;
  localparam int SUM_W      = INT_PROD_W + 2;
  localparam int FRAC_SHIFT = 8;
  localparam int TORQUE_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_LO   = 3'd0,
    REG_PROP_HI   = 3'd1,
    REG_INTEG_LO  = 3'd2,
    REG_INTEG_HI  = 3'd3,
    REG_DERIV_LO  = 3'd4,
    REG_DERIV_HI  = 3'd5,
    REG_LIMIT_LO  = 3'd6,
    REG_LIMIT_HI  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] velocity;
    logic signed [POS_W-1:0] target_position;
    logic signed [POS_W-1:0] target_velocity;
    logic                    target_fresh;
  } sample_t;

  typedef struct packed {
    logic [JOINT_W-1:0]         joint_out;
    logic signed [TORQUE_W-1:0] torque;
  } result_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [GAIN_W-1:0] clamp;
  } gains_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        joint;
    logic                      run;
    logic signed [ERR_W-1:0]   pe;
    logic signed [ERR_W-1:0]   ve;
    logic signed [INTEG_W-1:0] acc;
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [GAIN_W-1:0]  kd;
  } stage1_t;

  typedef struct packed {
    logic [JOINT_W-1:0]           joint;
    logic                         run;
    logic signed [PE_PROD_W-1:0]  p_prod;
    logic signed [INT_PROD_W-1:0] i_prod;
    logic signed [PE_PROD_W-1:0]  d_prod;
  } stage2_t;

  // Picks joint j's Q8.8 halfword from a low/high register pair.
  function automatic logic signed [GAIN_W-1:0] gain_sel(
    input logic [CFG_W-1:0]   lo,
    input logic [CFG_W-1:0]   hi,
    input logic [JOINT_W-1:0] joint
  );
    logic [CFG_W-1:0] w;
    w = joint[2] ? hi : lo;
    return w[{joint[1:0], 4'b0000} +: GAIN_W];
  endfunction

endpackage

@@ design/mjpid_cfg.sv @@
// Configuration register file and per-joint gain lookup.
// Depends on mjpid_pkg.
`timescale 1ns / 1ps

module mjpid_cfg
  import mjpid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [JOINT_W-1:0]   joint,
  output gains_t               gains
);

  logic [CFG_W-1:0] regs [CFG_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    gains.kp    = gain_sel(regs[REG_PROP_LO], regs[REG_PROP_HI], joint);
    gains.ki    = gain_sel(regs[REG_INTEG_LO], regs[REG_INTEG_HI], joint);
    gains.kd    = gain_sel(regs[REG_DERIV_LO], regs[REG_DERIV_HI], joint);
    gains.clamp = gain_sel(regs[REG_LIMIT_LO], regs[REG_LIMIT_HI], joint);
  end

endmodule

@@ design/mjpid_integ.sv @@
// Error stage: position/velocity errors and the per-joint integrator update.
// Depends on mjpid_pkg.
`timescale 1ns / 1ps

module mjpid_integ
  import mjpid_pkg::*;
#(
  parameter int JOINTS = 7
) (
  input  logic    clk,
  input  logic    rst,
  input  sample_t s0,
  input  logic    s0_valid,
  input  logic    en1,
  input  gains_t  gains,
  output stage1_t s1
);

  localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic signed [INTEG_W-1:0] integ_q [JOINTS];

  logic [IDX_W-1:0]          idx;
  logic                      in_range;
  logic                      run;
  logic signed [ERR_W-1:0]   pe;
  logic signed [ERR_W-1:0]   ve;
  logic signed [INTEG_W-1:0] acc_rd;
  logic [GAIN_W:0]           clamp_mag;
  logic signed [INTEG_W:0]   lim;
  logic signed [INTEG_W:0]   acc_ext;
  logic signed [INTEG_W:0]   sum_ext;
  logic                      below;
  logic signed [INTEG_W-1:0] acc_sat;
  logic signed [INTEG_W-1:0] acc_new;
  logic                      wr;

  always_comb begin
    idx      = s0.joint[IDX_W-1:0];
    in_range = {1'b0, s0.joint} < (JOINT_W + 1)'(JOINTS);
    run      = s0.target_fresh && in_range;
    pe = {s0.target_position[POS_W-1], s0.target_position}
       - {s0.position[POS_W-1], s0.position};
    ve = {s0.target_velocity[POS_W-1], s0.target_velocity}
       - {s0.velocity[POS_W-1], s0.velocity};
    acc_rd = in_range ? integ_q[idx] : '0;

    // |clamp| as unsigned Q9.8; the most negative code maps to +32768
    clamp_mag = gains.clamp[GAIN_W-1] ? ((GAIN_W + 1)'(0) - {1'b1, gains.clamp})
                                      : {1'b0, gains.clamp};
    lim = $signed({{(INTEG_W + 1 - CLAMP_W){1'b0}}, clamp_mag, 8'b0});

    acc_ext = {acc_rd[INTEG_W-1], acc_rd};
    below   = (acc_ext < lim) && (acc_ext > -lim);
    sum_ext = acc_ext + {{(INTEG_W + 1 - ERR_W){pe[ERR_W-1]}}, pe};

    if (sum_ext[INTEG_W] != sum_ext[INTEG_W-1]) begin
      acc_sat = sum_ext[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                 : {1'b0, {(INTEG_W - 1){1'b1}}};
    end else begin
      acc_sat = sum_ext[INTEG_W-1:0];
    end

    acc_new = below ? acc_sat : acc_rd;
    wr      = s0_valid && en1 && run && below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINTS; i++) begin
        integ_q[i] <= '0;
      end
    end else if (wr) begin
      integ_q[idx] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1.joint <= s0.joint;
      s1.run   <= run;
      s1.pe    <= pe;
      s1.ve    <= ve;
      s1.acc   <= acc_new;
      s1.kp    <= gains.kp;
      s1.ki    <= gains.ki;
      s1.kd    <= gains.kd;
    end
  end

  // at or beyond the clamp the integrator is passed through untouched
  a_hold_at_clamp: assert property (@(posedge clk) disable iff (rst)
    s0_valid && en1 && run && !below |=> s1.acc == $past(acc_rd))
    else $error("integrator moved while at its clamp");

  a_no_write_stale: assert property (@(posedge clk) disable iff (rst)
    wr |-> s0.target_fresh && in_range)
    else $error("integrator written for a stale or out-of-range sample");

endmodule

@@ design/mjpid_mac.sv @@
// Product stage and sum/round/saturate stage feeding the result register.
// Depends on mjpid_pkg.
`timescale 1ns / 1ps

module mjpid_mac
  import mjpid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  stage1_t s1,
  input  logic    en2,
  input  logic    s2_valid,
  input  logic    en3,
  output result_t result
);

  stage2_t s2;

  logic signed [SUM_W-1:0]    sum;
  logic signed [TORQUE_W-1:0] torque_sat;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2.joint  <= s1.joint;
      s2.run    <= s1.run;
      s2.p_prod <= $signed(s1.kp) * $signed(s1.pe);
      s2.i_prod <= $signed(s1.ki) * $signed(s1.acc);
      s2.d_prod <= $signed(s1.kd) * $signed(s1.ve);
    end
  end

  always_comb begin
    sum = {{(SUM_W - PE_PROD_W){s2.p_prod[PE_PROD_W-1]}}, s2.p_prod}
        + {{(SUM_W - INT_PROD_W){s2.i_prod[INT_PROD_W-1]}}, s2.i_prod}
        + {{(SUM_W - PE_PROD_W){s2.d_prod[PE_PROD_W-1]}}, s2.d_prod};
    // floor shift by 8, then clip to 32 bits
    if (sum[SUM_W-1:FRAC_SHIFT+TORQUE_W-1] == '0 ||
        sum[SUM_W-1:FRAC_SHIFT+TORQUE_W-1] == '1) begin
      torque_sat = sum[FRAC_SHIFT+TORQUE_W-1:FRAC_SHIFT];
    end else begin
      torque_sat = sum[SUM_W-1] ? {1'b1, {(TORQUE_W - 1){1'b0}}}
                                : {1'b0, {(TORQUE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      result.joint_out <= s2.joint;
      result.torque    <= s2.run ? torque_sat : '0;
    end
  end

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    en3 && s2_valid && !s2.run |=> result.torque == '0)
    else $error("stale or out-of-range sample gave nonzero torque");

endmodule

@@ design/multi_joint_pid_with_integral_clamp.sv @@
// Top level of the multi-joint PID controller with integrator clamping.
// Depends on mjpid_pkg, mjpid_cfg, mjpid_integ, mjpid_mac.
//
// Usage:
//   sample channel (sample_valid/sample_stall/sample) carries one joint sample
//   per transaction; result channel (result_valid/result_stall/result) returns
//   one torque per sample, in order. The cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data) writes the eight 64-bit gain/clamp registers; it is
//   always ready and should be written only while no samples are in flight.
// Path: a sample accepted on the input passes through the input register,
//   error/integrator stage, product register and result register, in order.
// Throughput: one sample per cycle while sample_stall is low; the integrator
//   read-modify-write for a joint completes within the error stage, so
//   back-to-back samples to the same joint see each other's updates.
// Stall: each stage advances when the one after it is empty or moving, so
//   bubbles are squeezed out; sample_stall rises only once all four stages hold
//   transactions and result_stall is high.
// Reset (rst, synchronous): clears all config registers, all integrators and
//   every stage's valid bit; the block takes samples the cycle after.
`timescale 1ns / 1ps

module multi_joint_pid_with_integral_clamp
  import mjpid_pkg::*;
#(
  parameter int JOINTS = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sample_t s0;
  stage1_t s1;
  gains_t  gains;

  logic v0, v1, v2;
  logic en0, en1, en2, en3;

  always_comb begin
    en3 = !result_valid || !result_stall;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
    en0 = !v0 || en1;
  end

  assign sample_stall = !en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en0) v0 <= sample_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && sample_valid) begin
      s0 <= sample;
    end
  end

  mjpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .joint     (s0.joint),
    .gains     (gains)
  );

  mjpid_integ #(
    .JOINTS (JOINTS)
  ) u_integ (
    .clk      (clk),
    .rst      (rst),
    .s0       (s0),
    .s0_valid (v0),
    .en1      (en1),
    .gains    (gains),
    .s1       (s1)
  );

  mjpid_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .en2      (en2),
    .s2_valid (v2),
    .en3      (en3),
    .result   (result)
  );

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> v0)
    else $error("accepted transaction not captured in input stage");

  a_empty_out_accepts: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("input stalled while result register is empty");

  a_drain_to_result: assert property (@(posedge clk) disable iff (rst)
    v2 && en3 |=> result_valid)
    else $error("product stage transaction lost before result register");

endmodule
